[design/skm_pkg.sv]
// shared types and constants for the symmetric kernel spectral multiply unit
package skm_pkg;

  localparam int IDX_W     = 5;
  localparam int LOG_W     = 3;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 6;

  localparam logic [LOG_W-1:0] LOG2_X_RST = 3'd5;
  localparam logic [LOG_W-1:0] LOG2_Y_RST = 3'd5;
  localparam logic [LOG_W-1:0] LOG2_Z_RST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_X    = 3'd0,
    CFG_LOG2_Y    = 3'd1,
    CFG_LOG2_Z    = 3'd2,
    CFG_THREE_DIM = 3'd3,
    CFG_OFF_DIAG  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MUL  = 1'b1
  } req_type_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } skm_adv_t;

endpackage

[design/symmetric_kernel_spectral_multiply_unit.sv]
// top level: kernel memory, address folding, product pipeline and output register
//
// Takes one item per clock unless a stalled output has backed up the pipeline. A load
// item with indices in range writes the three kernel words of one reduced coordinate
// into the kernel memory in the cycle it is accepted and gives no result. A multiply
// item reads the memory (registered read) and runs through four arithmetic stages
// (partial products, sum, round, saturate); the last one drives the output. The memory
// holds (2**(MAX_LOG2_X-1)+1)*(2**(MAX_LOG2_Y-1)+1)*(2**(MAX_LOG2_Z-1)+1) words of
// 3*DATA_WIDTH bits, is not cleared, and reads of entries never loaded are undefined.
// A result waiting on the output does not block input while earlier stages hold bubbles.
module symmetric_kernel_spectral_multiply_unit
  import skm_pkg::*;
#(
  parameter int MAX_LOG2_X = 5,
  parameter int MAX_LOG2_Y = 5,
  parameter int MAX_LOG2_Z = 4,
  parameter int DATA_WIDTH = 32,
  localparam int IN_BITS   = 3 * IDX_W + 6 * DATA_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = IDX_W + 6 * DATA_WIDTH,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // idx_i, idx_j, line_pos, in_x_re, in_x_im, in_y_re, in_y_im, in_z_re, in_z_im
  input  logic [IN_W-1:0]      in_tdata,
  // req_type
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_pos, out_x_re, out_x_im, out_y_re, out_y_im, out_z_re, out_z_im
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG_W-1:0]     cfg_data
);

  localparam int DW     = DATA_WIDTH;
  localparam int KW     = 3 * DW;
  localparam int RX     = 2 ** (MAX_LOG2_X - 1) + 1;
  localparam int RY     = 2 ** (MAX_LOG2_Y - 1) + 1;
  localparam int RZ     = 2 ** (MAX_LOG2_Z - 1) + 1;
  localparam int DEPTH  = RX * RY * RZ;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = (MAX_LOG2_X > IDX_W) ? MAX_LOG2_X : IDX_W;
  localparam int YW     = (MAX_LOG2_Y > IDX_W) ? MAX_LOG2_Y : IDX_W;
  localparam int ZW     = (MAX_LOG2_Z > IDX_W) ? MAX_LOG2_Z : IDX_W;

  // configuration
  logic [LOG_W-1:0] log2_x_r;
  logic [LOG_W-1:0] log2_y_r;
  logic [LOG_W-1:0] log2_z_r;
  logic             three_dim_r;
  logic             off_diag_r;

  logic [LOG_W-1:0] lx;
  logic [LOG_W-1:0] ly;
  logic [LOG_W-1:0] lz;
  logic [XW-1:0]    hx;
  logic [YW-1:0]    hy;
  logic [ZW-1:0]    hz;
  logic [IDX_W-1:0] mask_y;
  logic [IDX_W-1:0] mask_z;

  // input unpacking and address folding
  logic [IDX_W-1:0] in_i;
  logic [IDX_W-1:0] in_j;
  logic [IDX_W-1:0] in_p;
  logic [DW-1:0]    in_word [NUM_LANES];
  logic             is_mul;
  logic [IDX_W-1:0] row_m;
  logic             row_high;
  logic [IDX_W-1:0] row_fold;
  logic [IDX_W-1:0] z_m;
  logic             z_high;
  logic [IDX_W-1:0] z_fold;
  logic [XW-1:0]    i_sat;
  logic             ld_ok;
  logic [XW-1:0]    a_i;
  logic [IDX_W-1:0] a_y;
  logic [IDX_W-1:0] a_z;
  logic [ADDR_W-1:0] t_row;
  logic [ADDR_W-1:0] addr;
  logic [2:0]       neg_in;
  logic             zero_yz;
  logic [IDX_W-1:0] pos_in;
  logic             in_xfer;
  logic             mem_we;
  logic             mem_re;

  // kernel memory
  logic [KW-1:0]    kmem [DEPTH];
  logic [KW-1:0]    kern_rd_r;

  // pipeline control and payload
  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  logic             rdy1, rdy2, rdy3, rdy4, rdy5;
  skm_adv_t         adv;
  logic [DW-1:0]    d1_r [NUM_LANES];
  logic [2:0]       neg1_r;
  logic [IDX_W-1:0] pos1_r, pos2_r, pos3_r, pos4_r, pos5_r;
  logic [DW-1:0]    res [NUM_LANES];
  logic [OUT_BITS-1:0] out_bits;

  function automatic logic [LOG_W-1:0] clamp_log(input logic [LOG_W-1:0] v, input int maxv);
    logic [LOG_W-1:0] r;
    if (v == '0) begin
      r = LOG_W'(1);
    end else if (int'(v) > maxv) begin
      r = LOG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_x_r    <= LOG2_X_RST;
      log2_y_r    <= LOG2_Y_RST;
      log2_z_r    <= LOG2_Z_RST;
      three_dim_r <= 1'b0;
      off_diag_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOG2_X:    log2_x_r    <= cfg_data;
        CFG_LOG2_Y:    log2_y_r    <= cfg_data;
        CFG_LOG2_Z:    log2_z_r    <= cfg_data;
        CFG_THREE_DIM: three_dim_r <= cfg_data[0];
        CFG_OFF_DIAG:  off_diag_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lx     = clamp_log(log2_x_r, MAX_LOG2_X);
    ly     = clamp_log(log2_y_r, MAX_LOG2_Y);
    lz     = clamp_log(log2_z_r, MAX_LOG2_Z);
    hx     = XW'(1) << (lx - LOG_W'(1));
    hy     = YW'(1) << (ly - LOG_W'(1));
    hz     = ZW'(1) << (lz - LOG_W'(1));
    mask_y = ~({IDX_W{1'b1}} << ly);
    mask_z = ~({IDX_W{1'b1}} << lz);
  end

  always_comb begin
    in_i = in_tdata[IDX_W-1:0];
    in_j = in_tdata[2*IDX_W-1:IDX_W];
    in_p = in_tdata[3*IDX_W-1:2*IDX_W];
    for (int l = 0; l < NUM_LANES; l++) begin
      in_word[l] = in_tdata[3*IDX_W + l*DW +: DW];
    end
    is_mul = (req_type_t'(in_tuser) == REQ_MUL);

    // lines along y in 2d take the row from line_pos, in 3d from idx_j
    row_m    = (three_dim_r ? in_j : in_p) & mask_y;
    row_high = YW'(row_m) > hy;
    row_fold = row_high ? ((IDX_W'(0) - row_m) & mask_y) : row_m;
    z_m      = in_p & mask_z;
    z_high   = ZW'(z_m) > hz;
    z_fold   = z_high ? ((IDX_W'(0) - z_m) & mask_z) : z_m;
    i_sat    = (XW'(in_i) > hx) ? hx : XW'(in_i);

    ld_ok = !(XW'(in_i) > hx) && !(YW'(in_j) > hy) && !(three_dim_r && (ZW'(in_p) > hz));

    a_i = is_mul ? i_sat : XW'(in_i);
    a_y = is_mul ? row_fold : in_j;
    if (three_dim_r) begin
      a_z = is_mul ? z_fold : in_p;
    end else begin
      a_z = '0;
    end
    t_row = ADDR_W'(a_y) + (ADDR_W'(a_z) << (ly - LOG_W'(1))) + ADDR_W'(a_z);
    addr  = ADDR_W'(a_i) + (t_row << (lx - LOG_W'(1))) + t_row;

    neg_in[0] = off_diag_r && row_high;
    neg_in[1] = off_diag_r && three_dim_r && z_high;
    neg_in[2] = off_diag_r && three_dim_r && (row_high ^ z_high);
    zero_yz   = off_diag_r && !three_dim_r;
    pos_in    = three_dim_r ? z_m : row_m;
  end

  // ready ripples back so bubbles are squeezed out behind a stalled output
  always_comb begin
    rdy5 = !v5_r || out_tready;
    rdy4 = !v4_r || rdy5;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    adv.s2 = rdy2;
    adv.s3 = rdy3;
    adv.s4 = rdy4;
    adv.s5 = rdy5;
  end

  assign in_tready = rdy1;
  assign in_xfer   = in_tvalid && in_tready;
  assign mem_we    = in_xfer && !is_mul && ld_ok;
  assign mem_re    = in_xfer && is_mul;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kmem[addr] <= {in_word[4], in_word[2], in_word[0]};
    end
    if (mem_re) begin
      kern_rd_r <= kmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid && is_mul;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        // 2d off-diagonal kernel has only x, so y and z products are forced to zero
        d1_r[l] <= (zero_yz && l >= 2) ? '0 : in_word[l];
      end
      neg1_r <= neg_in;
      pos1_r <= pos_in;
    end
    if (rdy2) pos2_r <= pos1_r;
    if (rdy3) pos3_r <= pos2_r;
    if (rdy4) pos4_r <= pos3_r;
    if (rdy5) pos5_r <= pos4_r;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    skm_lane #(
      .DATA_WIDTH(DW)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .kern   (kern_rd_r[(l/2)*DW +: DW]),
      .data   (d1_r[l]),
      .negate (neg1_r[l/2]),
      .result (res[l])
    );
  end

  always_comb begin
    out_bits[IDX_W-1:0] = pos5_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      out_bits[IDX_W + l*DW +: DW] = res[l];
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = OUT_W'(out_bits);

endmodule

[design/skm_lane.sv]
// one product lane: split multiply, sum, round half away from zero, saturate
module skm_lane
  import skm_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  skm_adv_t                     adv,
  input  logic signed [DATA_WIDTH-1:0] kern,
  input  logic signed [DATA_WIDTH-1:0] data,
  input  logic                         negate,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int DW   = DATA_WIDTH;
  localparam int LO_W = DW / 2;
  localparam int HI_W = DW - LO_W;
  localparam int PW   = 2 * DW;
  localparam int RW   = PW - FRAC_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic signed [DW+LO_W:0]   pp_lo;
  logic signed [DW+HI_W-1:0] pp_hi;
  logic signed [DW+LO_W:0]   pp_lo_r;
  logic signed [DW+HI_W-1:0] pp_hi_r;
  logic                      neg2_r;
  logic [PW-1:0]             prod_nxt;
  logic [PW-1:0]             prod_r;
  logic                      neg3_r;
  logic [PW-1:0]             mag;
  logic [RW-1:0]             mag_r;
  logic                      rneg_r;
  logic [DW-1:0]             limit;
  logic [DW-1:0]             sat;
  logic [DW-1:0]             result_nxt;
  logic [DW-1:0]             result_r;

  // partial products against the low and high halves of the data word
  always_comb begin
    pp_lo = kern * $signed({1'b0, data[LO_W-1:0]});
    pp_hi = kern * $signed(data[DW-1:LO_W]);
  end

  always_comb begin
    prod_nxt = ({{LO_W{pp_hi_r[DW+HI_W-1]}}, pp_hi_r} << LO_W)
             + {{(HI_W-1){pp_lo_r[DW+LO_W]}}, pp_lo_r};
  end

  // magnitude plus rounding constant in one add
  always_comb begin
    if (prod_r[PW-1]) begin
      mag = ~prod_r + (RND + PW'(1));
    end else begin
      mag = prod_r + RND;
    end
  end

  always_comb begin
    limit = {rneg_r, {(DW-1){~rneg_r}}};
    if (mag_r > RW'(limit)) begin
      sat = limit;
    end else begin
      sat = mag_r[DW-1:0];
    end
    result_nxt = rneg_r ? (DW'(0) - sat) : sat;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pp_lo_r <= pp_lo;
      pp_hi_r <= pp_hi;
      neg2_r  <= negate;
    end
    if (adv.s3) begin
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
    end
    if (adv.s4) begin
      mag_r  <= mag[PW-1:FRAC_BITS];
      rneg_r <= prod_r[PW-1] ^ neg3_r;
    end
    if (adv.s5) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

[design/skm_checker.sv]
// port-level checks for the symmetric kernel spectral multiply unit, with bind
module skm_checker
  import skm_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  localparam int OUT_BITS  = IDX_W + 6 * DATA_WIDTH,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic mul_xfer;

  assign mul_xfer = in_tvalid && in_tready && (req_type_t'(in_tuser) == REQ_MUL);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_free_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    mul_xfer ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("multiply result missing after pipeline latency");

endmodule

bind symmetric_kernel_spectral_multiply_unit skm_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_skm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/skm_product_checker.sv]
// checker for the spectral multiply unit: mirrors the kernel store, predicts and compares products
module skm_product_checker
  import skm_pkg::*;
#(
  parameter int MAX_LOG2_X = 5,
  parameter int MAX_LOG2_Y = 5,
  parameter int MAX_LOG2_Z = 4,
  parameter int IN_W       = 208,
  parameter int OUT_W      = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG_W-1:0]     cfg_data,
  output int                   due_count,
  output int                   mismatches
);

  localparam int WORD_W = 32;
  localparam int DEPTH  = ((1 << (MAX_LOG2_X - 1)) + 1) * ((1 << (MAX_LOG2_Y - 1)) + 1)
                          * ((1 << (MAX_LOG2_Z - 1)) + 1);

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] lanes_t;
  typedef struct packed {
    logic [IDX_W-1:0] pos;
    lanes_t           lane;
  } product_t;

  logic [WORD_W-1:0] kern_x [DEPTH];
  logic [WORD_W-1:0] kern_y [DEPTH];
  logic [WORD_W-1:0] kern_z [DEPTH];
  logic [LOG_W-1:0]  log_x = LOG2_X_RST;
  logic [LOG_W-1:0]  log_y = LOG2_Y_RST;
  logic [LOG_W-1:0]  log_z = LOG2_Z_RST;
  logic              three_d = 1'b0;
  logic              odd_kernel = 1'b0;
  product_t          product_q [$];
  int                errors = 0;
  string             lane_tag [NUM_LANES] = '{"x_re", "x_im", "y_re", "y_im", "z_re", "z_im"};

  logic [IDX_W-1:0]  c_i, c_j, c_p;
  lanes_t            c_words;
  product_t          got, want;

  function automatic int span_log(logic [LOG_W-1:0] v, int top);
    if (v < 1) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // exact product, round half away from zero, saturate to the word range
  function automatic logic [WORD_W-1:0] q_product(logic [WORD_W-1:0] k, logic [WORD_W-1:0] d,
                                                  bit flip);
    longint     prod;
    logic [63:0] mag;
    logic [63:0] rnd;
    bit          neg;
    prod = longint'(signed'(k)) * longint'(signed'(d));
    neg  = (prod < 0) ^ flip;
    mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
    rnd  = (mag + 64'd32768) >> FRAC_BITS;
    if (neg) begin
      if (rnd > 64'h8000_0000) rnd = 64'h8000_0000;
      return WORD_W'(-rnd);
    end
    if (rnd > 64'h7fff_ffff) rnd = 64'h7fff_ffff;
    return rnd[WORD_W-1:0];
  endfunction

  task automatic store_kernel(logic [IDX_W-1:0] xi, yj, lp, lanes_t w);
    int hx, hy, hz, row, addr;
    hx   = 1 << (span_log(log_x, MAX_LOG2_X) - 1);
    hy   = 1 << (span_log(log_y, MAX_LOG2_Y) - 1);
    hz   = 1 << (span_log(log_z, MAX_LOG2_Z) - 1);
    row  = hx + 1;
    if (int'(xi) > hx || int'(yj) > hy) return;
    addr = int'(xi) + int'(yj) * row;
    if (three_d) begin
      if (int'(lp) > hz) return;
      addr = addr + int'(lp) * row * (hy + 1);
    end
    if (addr >= DEPTH) return;
    kern_x[addr] = w[0];
    kern_y[addr] = w[2];
    kern_z[addr] = w[4];
  endtask

  function automatic product_t fold_multiply(logic [IDX_W-1:0] xi, yj, lp, lanes_t w);
    int       hx, hy, hz, ny, nz, row, col, ry, rz, y_raw, pos_v, addr;
    bit       hi_y, hi_z, neg_x, neg_y, neg_z, yz_off;
    product_t r;
    hx     = 1 << (span_log(log_x, MAX_LOG2_X) - 1);
    hy     = 1 << (span_log(log_y, MAX_LOG2_Y) - 1);
    hz     = 1 << (span_log(log_z, MAX_LOG2_Z) - 1);
    ny     = 1 << span_log(log_y, MAX_LOG2_Y);
    nz     = 1 << span_log(log_z, MAX_LOG2_Z);
    row    = hx + 1;
    col    = (int'(xi) > hx) ? hx : int'(xi);
    neg_x  = 1'b0;
    neg_y  = 1'b0;
    neg_z  = 1'b0;
    yz_off = 1'b0;
    if (!three_d) begin
      pos_v = int'(lp) & (ny - 1);
      hi_y  = pos_v > hy;
      ry    = hi_y ? ny - pos_v : pos_v;
      rz    = 0;
      if (odd_kernel) begin
        neg_x  = hi_y;
        yz_off = 1'b1;
      end
    end else begin
      y_raw = int'(yj) & (ny - 1);
      hi_y  = y_raw > hy;
      ry    = hi_y ? ny - y_raw : y_raw;
      pos_v = int'(lp) & (nz - 1);
      hi_z  = pos_v > hz;
      rz    = hi_z ? nz - pos_v : pos_v;
      if (odd_kernel) begin
        neg_x = hi_y;
        neg_y = hi_z;
        neg_z = hi_y ^ hi_z;
      end
    end
    addr = col + ry * row + rz * row * (hy + 1);
    if (addr >= DEPTH) addr = 0;
    r.pos     = pos_v[IDX_W-1:0];
    r.lane[0] = q_product(kern_x[addr], w[0], neg_x);
    r.lane[1] = q_product(kern_x[addr], w[1], neg_x);
    r.lane[2] = q_product(kern_y[addr], w[2], neg_y);
    r.lane[3] = q_product(kern_y[addr], w[3], neg_y);
    r.lane[4] = q_product(kern_z[addr], w[4], neg_z);
    r.lane[5] = q_product(kern_z[addr], w[5], neg_z);
    if (yz_off) begin
      for (int n = 2; n < NUM_LANES; n++) r.lane[n] = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      log_x      = LOG2_X_RST;
      log_y      = LOG2_Y_RST;
      log_z      = LOG2_Z_RST;
      three_d    = 1'b0;
      odd_kernel = 1'b0;
      product_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LOG2_X:    log_x = cfg_data;
          CFG_LOG2_Y:    log_y = cfg_data;
          CFG_LOG2_Z:    log_z = cfg_data;
          CFG_THREE_DIM: three_d = cfg_data[0];
          CFG_OFF_DIAG:  odd_kernel = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.pos = out_tdata[IDX_W-1:0];
        for (int n = 0; n < NUM_LANES; n++) got.lane[n] = out_tdata[IDX_W + n*WORD_W +: WORD_W];
        if (product_q.size() == 0) begin
          errors++;
          $display("%0t: product transfer with none expected, pos %0d", $time, got.pos);
        end else begin
          want = product_q.pop_front();
          if (got.pos !== want.pos) begin
            errors++;
            $display("%0t: pos expected %0d actual %0d", $time, want.pos, got.pos);
          end
          for (int n = 0; n < NUM_LANES; n++) begin
            if (got.lane[n] !== want.lane[n]) begin
              errors++;
              $display("%0t: %s expected %h actual %h", $time, lane_tag[n], want.lane[n],
                       got.lane[n]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        c_i = in_tdata[0 +: IDX_W];
        c_j = in_tdata[IDX_W +: IDX_W];
        c_p = in_tdata[2*IDX_W +: IDX_W];
        for (int n = 0; n < NUM_LANES; n++) c_words[n] = in_tdata[3*IDX_W + n*WORD_W +: WORD_W];
        if (req_type_t'(in_tuser) == REQ_MUL) product_q.push_back(fold_multiply(c_i, c_j, c_p,
                                                                                c_words));
        else store_kernel(c_i, c_j, c_p, c_words);
      end
    end
    due_count  <= product_q.size();
    mismatches <= errors;
  end

endmodule

[dv/tb_symmetric_kernel_spectral_multiply_unit.sv]
// testbench top for the spectral multiply unit: clock, reset, stimulus and verdict
module tb_symmetric_kernel_spectral_multiply_unit;
  import skm_pkg::*;

  localparam int WORD_W = 32;
  localparam int IN_W   = ((3 * IDX_W + NUM_LANES * WORD_W + 7) / 8) * 8;
  localparam int OUT_W  = ((IDX_W + NUM_LANES * WORD_W + 7) / 8) * 8;

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] lanes_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index = CFG_LOG2_X;
  logic [LOG_W-1:0]     cfg_data = '0;
  int                   due_count;
  int                   mismatches;

  bit                   src_idle_on = 1'b1;
  bit                   snk_idle_on = 1'b1;
  int                   stall_left = 0;
  int                   cur_hx, cur_hy, cur_hz;
  bit                   cur_3d;

  symmetric_kernel_spectral_multiply_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  skm_product_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .due_count  (due_count),
    .mismatches (mismatches)
  );

  always #5 clk = ~clk;

  // result side backpressure in short bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 7))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          4: v = 32'h0000_0001;
          5: v = 32'h0000_8000;
          6: v = 32'hffff_8000;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0003_ffff);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic lanes_t rand_lanes();
    lanes_t w;
    for (int n = 0; n < NUM_LANES; n++) w[n] = rand_word();
    return w;
  endfunction

  function automatic lanes_t mk(logic [WORD_W-1:0] a, b, c, d, e, f);
    lanes_t w;
    w[0] = a;
    w[1] = b;
    w[2] = c;
    w[3] = d;
    w[4] = e;
    w[5] = f;
    return w;
  endfunction

  function automatic int half_of(logic [LOG_W-1:0] v, int top);
    int l;
    l = (v < 1) ? 1 : ((int'(v) > top) ? top : int'(v));
    return 1 << (l - 1);
  endfunction

  task automatic send_item(input req_type_t req, input logic [IDX_W-1:0] ci, cj, cp,
                           input lanes_t w);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_W'({w, cp, cj, ci});
    do @(posedge clk); while (!in_tready);
  endtask

  // hold input until every product has come out, then let loads settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(input logic [LOG_W-1:0] lx, ly, lz, input logic td, od);
    cfg_valid <= 1'b1;
    for (int r = 0; r < 5; r++) begin
      cfg_index <= cfg_reg_t'(r);
      case (cfg_reg_t'(r))
        CFG_LOG2_X:    cfg_data <= lx;
        CFG_LOG2_Y:    cfg_data <= ly;
        CFG_LOG2_Z:    cfg_data <= lz;
        CFG_THREE_DIM: cfg_data <= LOG_W'(td);
        default:       cfg_data <= LOG_W'(od);
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_hx = half_of(lx, 5);
    cur_hy = half_of(ly, 5);
    cur_hz = half_of(lz, 4);
    cur_3d = td;
  endtask

  // every reduced coordinate gets a kernel before any multiply reads it
  task automatic load_grid();
    int kz;
    kz = cur_3d ? cur_hz : 0;
    for (int k = 0; k <= kz; k++)
      for (int j = 0; j <= cur_hy; j++)
        for (int i = 0; i <= cur_hx; i++)
          send_item(REQ_LOAD, IDX_W'(i), IDX_W'(j),
                    cur_3d ? IDX_W'(k) : IDX_W'($urandom_range(0, 31)), rand_lanes());
  endtask

  task automatic random_items(input int n_mul);
    int sent;
    int pick;
    int ci;
    sent = 0;
    while (sent < n_mul) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(REQ_LOAD, IDX_W'($urandom_range(0, cur_hx)), IDX_W'($urandom_range(0, cur_hy)),
                  IDX_W'(cur_3d ? $urandom_range(0, cur_hz) : $urandom_range(0, 31)),
                  rand_lanes());
      end else if (pick < 11) begin
        send_item(REQ_LOAD, IDX_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 31)),
                  IDX_W'($urandom_range(0, 31)), rand_lanes());
      end else begin
        ci = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_hx) : $urandom_range(0, 31);
        send_item(REQ_MUL, IDX_W'(ci), IDX_W'($urandom_range(0, 31)),
                  IDX_W'($urandom_range(0, 31)), rand_lanes());
        sent++;
      end
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  task automatic run_phase(input logic [LOG_W-1:0] lx, ly, lz, input logic td, od,
                           input int n_mul, input bit idle_src, idle_snk);
    src_idle_on = idle_src;
    snk_idle_on = idle_snk;
    set_config(lx, ly, lz, td, od);
    load_grid();
    random_items(n_mul);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_hx = 16;
    cur_hy = 16;
    cur_hz = 8;
    cur_3d = 1'b0;

    // reset geometry, even kernel: loads at grid corners and a few rejected loads
    send_item(REQ_LOAD, 5'd0, 5'd0, 5'd3,
              mk(32'h0001_0000, $urandom, 32'h7fff_ffff, $urandom, 32'h8000_0000, $urandom));
    send_item(REQ_LOAD, 5'd16, 5'd0, 5'd31,
              mk(32'h8000_0000, $urandom, 32'h0000_0001, $urandom, 32'hffff_ffff, $urandom));
    send_item(REQ_LOAD, 5'd0, 5'd1, 5'd0,
              mk(32'h0000_0001, $urandom, 32'hfffe_8000, $urandom, 32'h0002_0000, $urandom));
    send_item(REQ_LOAD, 5'd16, 5'd16, 5'd16,
              mk(32'h7fff_ffff, $urandom, 32'h0000_0000, $urandom, 32'h0001_0000, $urandom));
    send_item(REQ_LOAD, 5'd0, 5'd15, 5'd7,
              mk(32'hfffe_8000, $urandom, 32'h0001_0000, $urandom, 32'h7fff_ffff, $urandom));
    send_item(REQ_LOAD, 5'd17, 5'd0, 5'd0, rand_lanes());
    send_item(REQ_LOAD, 5'd31, 5'd31, 5'd31, rand_lanes());
    send_item(REQ_LOAD, 5'd0, 5'd17, 5'd0, rand_lanes());
    // saturation, index clamp, rounding ties, wrap, midpoint and fold
    send_item(REQ_MUL, 5'd0, 5'd31, 5'd0,
              mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                 32'h7fff_ffff));
    send_item(REQ_MUL, 5'd31, 5'd0, 5'd0,
              mk(32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 32'h8000_0000, 32'h1234_5678,
                 32'hdead_beef));
    send_item(REQ_MUL, 5'd0, 5'd21, 5'd1,
              mk(32'h0000_8000, 32'hffff_8000, 32'h0000_7fff, 32'h0001_8000, 32'hffff_ffff,
                 32'h0000_0001));
    send_item(REQ_MUL, 5'd0, 5'd10, 5'd31, rand_lanes());
    send_item(REQ_MUL, 5'd16, 5'd5, 5'd16, rand_lanes());
    send_item(REQ_MUL, 5'd0, 5'd16, 5'd17, rand_lanes());
    send_item(REQ_MUL, 5'd0, 5'd30, 5'd15, rand_lanes());
    drain();
    // odd kernel on the same entries
    set_config(3'd5, 3'd5, 3'd4, 1'b0, 1'b1);
    send_item(REQ_MUL, 5'd0, 5'd3, 5'd17, rand_lanes());
    send_item(REQ_MUL, 5'd16, 5'd12, 5'd16, rand_lanes());
    send_item(REQ_MUL, 5'd0, 5'd31, 5'd1, rand_lanes());
    send_item(REQ_MUL, 5'd0, 5'd0, 5'd31, rand_lanes());
    drain();

    run_phase(3'd3, 3'd4, 3'd2, 1'b0, 1'b0, 80, 1'b1, 1'b1);
    run_phase(3'd0, 3'd7, 3'd3, 1'b0, 1'b1, 80, 1'b1, 1'b0);
    run_phase(3'd2, 3'd2, 3'd1, 1'b1, 1'b0, 80, 1'b0, 1'b1);
    run_phase(3'd1, 3'd3, 3'd2, 1'b1, 1'b1, 80, 1'b1, 1'b1);
    run_phase(3'd1, 3'd0, 3'd7, 1'b1, 1'b1, 80, 1'b1, 1'b1);
    run_phase(3'd6, 3'd1, 3'd1, 1'b1, 1'b0, 80, 1'b1, 1'b1);
    run_phase(3'd2, 3'd6, 3'd0, 1'b0, 1'b1, 80, 1'b1, 1'b1);
    run_phase(3'd2, 3'd3, 3'd3, 1'b1, 1'b1, 80, 1'b1, 1'b1);
    run_phase(3'd1, 3'd5, 3'd5, 1'b0, 1'b1, 80, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("tb_symmetric_kernel_spectral_multiply_unit OK");
    end else begin
      $display("tb_symmetric_kernel_spectral_multiply_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_symmetric_kernel_spectral_multiply_unit NOT OK");
    $finish;
  end

endmodule

[files.f]
design/skm_pkg.sv
design/skm_lane.sv
design/symmetric_kernel_spectral_multiply_unit.sv
design/skm_checker.sv
dv/skm_product_checker.sv
dv/tb_symmetric_kernel_spectral_multiply_unit.sv
